@@ hw/rtl/backlight_curve_interpolator_defines.svh @@
// Assertion macros for the checker of the backlight curve block.
`ifndef BACKLIGHT_CURVE_INTERPOLATOR_DEFINES_SVH
`define BACKLIGHT_CURVE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bci_pkg.sv @@
package bci_pkg;

  localparam int LEVEL_BITS    = 10;
  localparam int VALUE_BITS    = 16;
  localparam int NUM_POINTS    = 4;
  localparam int PT_BITS       = $clog2(NUM_POINTS);
  localparam int IDX_BITS      = PT_BITS + 1;
  localparam int CFG_IDX_BITS  = PT_BITS + 1;
  localparam int CFG_DATA_BITS = (LEVEL_BITS > VALUE_BITS) ? LEVEL_BITS : VALUE_BITS;
  localparam int PROD_BITS     = LEVEL_BITS + VALUE_BITS;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);
  localparam int DIV_STAGES    = VALUE_BITS;
  // queue entries + multiply stage + divide stages + output register
  localparam int CAPACITY      = QDEPTH + DIV_STAGES + 2;

  typedef logic [LEVEL_BITS-1:0]    level_t;
  typedef logic [VALUE_BITS-1:0]    value_t;
  typedef logic [PROD_BITS-1:0]     prod_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [PT_BITS-1:0]       pt_t;
  typedef logic [QPTR_BITS-1:0]     qptr_t;
  typedef logic [QPTR_BITS:0]       qcnt_t;

  localparam level_t FLAT_LEVEL = level_t'(255);

  localparam cfg_idx_t REG_LEVEL_P0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LEVEL_P1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_LEVEL_P2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_LEVEL_P3 = cfg_idx_t'(3);
  localparam cfg_idx_t REG_VALUE_P0 = cfg_idx_t'(4);
  localparam cfg_idx_t REG_VALUE_P1 = cfg_idx_t'(5);
  localparam cfg_idx_t REG_VALUE_P2 = cfg_idx_t'(6);
  localparam cfg_idx_t REG_VALUE_P3 = cfg_idx_t'(7);

  // Classified item: result = base + level_diff * val_diff / den.
  // Flat cases carry level_diff = 0 and den = 1.
  typedef struct packed {
    level_t level_diff;
    value_t val_diff;
    level_t den;
    value_t base;
    logic   above_top;
  } item_t;

  typedef struct packed {
    prod_t  prod;
    level_t den;
    value_t base;
    logic   above_top;
  } mul_t;

  typedef struct packed {
    level_t rem;
    value_t low;
    value_t quo;
    level_t den;
    value_t base;
    logic   above_top;
  } div_t;

endpackage

@@ hw/rtl/bci_if.sv @@
interface bci_in_if;
  import bci_pkg::*;
  logic   valid;
  logic   ready;
  level_t level;
  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface bci_out_if;
  import bci_pkg::*;
  logic   valid;
  logic   ready;
  value_t drive_value;
  logic   above_top;
  modport source (output valid, output drive_value, output above_top, input ready);
  modport sink   (input valid, input drive_value, input above_top, output ready);
endinterface

interface bci_cfg_if;
  import bci_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bci_queue.sv @@
module bci_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bci_pkg::item_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bci_pkg::item_t pop_item
);
  import bci_pkg::*;

  item_t mem_r [QDEPTH];
  qptr_t wr_ptr_r, wr_ptr_nxt;
  qptr_t rd_ptr_r, rd_ptr_nxt;
  qcnt_t cnt_r, cnt_nxt;
  logic  do_push, do_pop;

  assign push_ready = (cnt_r != qcnt_t'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? qptr_t'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? qptr_t'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = qcnt_t'(cnt_r + qcnt_t'(do_push) - qcnt_t'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/bci_front.sv @@
module bci_front (
  input  logic           clk,
  input  logic           rst_n,
  bci_in_if.sink         in_if,
  bci_cfg_if.sink        cfg_if,
  output logic           push_valid,
  input  logic           push_ready,
  output bci_pkg::item_t push_item
);
  import bci_pkg::*;

  level_t lvl_r [NUM_POINTS];
  value_t val_r [NUM_POINTS];

  logic   stop, at_end, above, flat;
  idx_t   idx;
  pt_t    lo_pt, hi_pt;
  level_t lo_l, hi_l;
  value_t lo_v, hi_v;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        lvl_r[k] <= '0;
        val_r[k] <= '0;
      end
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_LEVEL_P0: lvl_r[0] <= cfg_if.data[LEVEL_BITS-1:0];
        REG_LEVEL_P1: lvl_r[1] <= cfg_if.data[LEVEL_BITS-1:0];
        REG_LEVEL_P2: lvl_r[2] <= cfg_if.data[LEVEL_BITS-1:0];
        REG_LEVEL_P3: lvl_r[3] <= cfg_if.data[LEVEL_BITS-1:0];
        REG_VALUE_P0: val_r[0] <= cfg_if.data[VALUE_BITS-1:0];
        REG_VALUE_P1: val_r[1] <= cfg_if.data[VALUE_BITS-1:0];
        REG_VALUE_P2: val_r[2] <= cfg_if.data[VALUE_BITS-1:0];
        REG_VALUE_P3: val_r[3] <= cfg_if.data[VALUE_BITS-1:0];
      endcase
    end
  end

  // Search for the first point at or below the level; a zero level ends the list.
  always_comb begin
    stop   = 1'b0;
    at_end = 1'b1;
    idx    = idx_t'(NUM_POINTS);
    for (int k = 0; k < NUM_POINTS; k++) begin
      if (!stop) begin
        if (lvl_r[k] == '0) begin
          stop = 1'b1;
          idx  = idx_t'(k);
        end else if (in_if.level >= lvl_r[k]) begin
          stop   = 1'b0 | 1'b1;
          at_end = 1'b0;
          idx    = idx_t'(k);
        end
      end
    end

    lo_pt = idx[PT_BITS-1:0];
    hi_pt = pt_t'(idx - 1'b1);
    lo_l  = at_end ? '0 : lvl_r[lo_pt];
    lo_v  = (idx == idx_t'(NUM_POINTS)) ? '0 : val_r[lo_pt];
    hi_l  = lvl_r[hi_pt];
    hi_v  = val_r[hi_pt];

    above = (in_if.level > lvl_r[0]);
    flat  = above || (idx == '0) || (in_if.level >= FLAT_LEVEL) || (lo_v == '0)
            || (hi_v < lo_v) || (hi_l <= lo_l);

    push_item.above_top = above;
    push_item.base      = above ? '0 : lo_v;
    if (flat) begin
      push_item.level_diff = '0;
      push_item.val_diff   = '0;
      push_item.den        = level_t'(1);
    end else begin
      push_item.level_diff = level_t'(in_if.level - lo_l);
      push_item.val_diff   = value_t'(hi_v - lo_v);
      push_item.den        = level_t'(hi_l - lo_l);
    end
  end

  assign push_valid  = in_if.valid;
  assign in_if.ready = push_ready;

endmodule

@@ hw/rtl/bci_back.sv @@
module bci_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  bci_pkg::item_t pop_item,
  bci_out_if.source      out_if
);
  import bci_pkg::*;

  logic   en;
  logic   m_valid_r;
  mul_t   m_r;
  logic   d_valid_r [DIV_STAGES];
  div_t   d_r [DIV_STAGES];
  div_t   d_init;
  logic   out_valid_r;
  value_t drive_r;
  logic   above_r;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic div_t div_step(div_t s);
    div_t r;
    logic [LEVEL_BITS:0] t;
    logic [LEVEL_BITS:0] d;
    r = s;
    t = {s.rem, s.low[VALUE_BITS-1]};
    d = {1'b0, s.den};
    r.low = {s.low[VALUE_BITS-2:0], 1'b0};
    if (t >= d) begin
      r.rem = LEVEL_BITS'(t - d);
      r.quo = {s.quo[VALUE_BITS-2:0], 1'b1};
    end else begin
      r.rem = t[LEVEL_BITS-1:0];
      r.quo = {s.quo[VALUE_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  assign en        = !out_valid_r || out_if.ready;
  assign pop_ready = en;

  always_comb begin
    d_init.rem       = m_r.prod[PROD_BITS-1 -: LEVEL_BITS];
    d_init.low       = m_r.prod[VALUE_BITS-1:0];
    d_init.quo       = '0;
    d_init.den       = m_r.den;
    d_init.base      = m_r.base;
    d_init.above_top = m_r.above_top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      m_valid_r    <= pop_valid;
      d_valid_r[0] <= m_valid_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_valid_r[k] <= d_valid_r[k-1];
      end
      out_valid_r  <= d_valid_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r.prod      <= prod_t'(pop_item.level_diff) * prod_t'(pop_item.val_diff);
      m_r.den       <= pop_item.den;
      m_r.base      <= pop_item.base;
      m_r.above_top <= pop_item.above_top;
      d_r[0]        <= div_step(d_init);
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_r[k] <= div_step(d_r[k-1]);
      end
      drive_r <= value_t'(d_r[DIV_STAGES-1].quo + d_r[DIV_STAGES-1].base);
      above_r <= d_r[DIV_STAGES-1].above_top;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.drive_value = drive_r;
  assign out_if.above_top   = above_r;

endmodule

@@ hw/rtl/backlight_curve_interpolator.sv @@
// Backlight curve interpolator: maps a brightness level to a drive value
// through up to four breakpoints written over the configuration channel.
//   cfg_if : register writes (index 0..3 levels, 4..7 values); always ready.
//            Write only while no item is in flight.
//   in_if  : one level per beat; valid/ready handshake.
//   out_if : one drive_value/above_top beat per input beat, in order.
// Path: an accepted level passes the queue hop, one multiply stage, 16 divide
//   stages and the output register before it shows on out_if.
// Throughput: one item per cycle while out_if is ready, with a 16-stage pipelined divider.
// Stall: a result held on out_if freezes the back pipeline as a whole; the
//   front keeps accepting into a 4-entry queue, then drops ready when full.
// Reset (rst_n low, synchronous): all breakpoints read 0, queue and pipeline
//   empty, no result pending.
module backlight_curve_interpolator (
  input  logic       clk,
  input  logic       rst_n,
  bci_in_if.sink     in_if,
  bci_out_if.source  out_if,
  bci_cfg_if.sink    cfg_if
);
  import bci_pkg::*;

  // front -> queue
  logic  push_valid, push_ready;
  item_t push_item;
  // queue -> back
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Classify the level against the breakpoints and hold the config registers.
  bci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the classifier from the arithmetic pipeline.
  bci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Multiply, divide and add; advance only when the output beat can move.
  bci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_if    (out_if)
  );

endmodule

@@ hw/rtl/bci_checker.sv @@
`include "backlight_curve_interpolator_defines.svh"

module bci_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input bci_pkg::value_t out_drive_value,
  input logic            out_above_top
);
  import bci_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic [CNT_BITS-1:0] inflight_r, inflight_nxt;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = CNT_BITS'(inflight_r + CNT_BITS'(in_acc) - CNT_BITS'(out_acc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `BCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive_value) && $stable(out_above_top), "result beat changed while stalled")
  `BCI_ASSERT_SAME(a_above_zero, out_valid && out_above_top, out_drive_value == '0, "above-top result with nonzero drive value")
  `BCI_ASSERT_SAME(a_no_phantom, out_valid, inflight_r != '0, "result beat with no level in flight")
  `BCI_ASSERT_SAME(a_ready_empty, inflight_r == '0, in_ready, "input not ready while block is empty")

endmodule

bind backlight_curve_interpolator bci_checker u_bci_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_drive_value (out_if.drive_value),
  .out_above_top   (out_if.above_top)
);

@@ tb/sv/backlight_curve_interpolator_tb.sv @@
module backlight_curve_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bci_pkg::*;

  localparam int LEVEL_MAX     = (1 << LEVEL_BITS) - 1;
  localparam int VALUE_MAX     = (1 << VALUE_BITS) - 1;
  // Idle wait after the last owed beat is back, before touching config.
  localparam int SETTLE_CYCLES = 24;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 200000;

  typedef level_t lvl_set_t [NUM_POINTS];
  typedef value_t val_set_t [NUM_POINTS];

  typedef struct packed {
    value_t drive_value;
    logic   above_top;
  } drive_beat_t;

  logic clk;
  logic rst_n;

  bci_in_if  in_bus ();
  bci_out_if out_bus ();
  bci_cfg_if cfg_bus ();

  backlight_curve_interpolator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus.sink),
    .out_if (out_bus.source),
    .cfg_if (cfg_bus.sink)
  );

  // Shadow copy of the breakpoint registers, as the block should hold them.
  level_t curve_level [NUM_POINTS] = '{default: '0};
  value_t curve_value [NUM_POINTS] = '{default: '0};

  // Drive beats still owed by the block, oldest first.
  drive_beat_t drive_expect [$];

  int  err_count    = 0;
  int  cycle_count  = 0;
  bit  idle_on      = 1'b1;
  bit  hold_active  = 1'b0;
  int  rx_gap       = 0;
  event long_hold;

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      @(long_hold);
      hold_active = 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Result-side ready: short random stall bursts while idling is on, a solid low
  // during a long hold, otherwise always ready.
  always @(negedge clk) begin
    if (hold_active) begin
      out_bus.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_bus.ready <= 1'b0;
      rx_gap--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      rx_gap = $urandom_range(0, 2);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Work out the drive beat for one level from the shadow curve.
  function automatic drive_beat_t map_level(input level_t lv);
    drive_beat_t      r;
    int unsigned      n;
    int unsigned      k;
    int unsigned      lo_l;
    int unsigned      lo_v;
    int unsigned      hi_l;
    int unsigned      hi_v;
    longint unsigned  num;
    r.above_top   = 1'b0;
    r.drive_value = '0;
    // The list ends at the first zero level.
    n = 0;
    while (n < NUM_POINTS && curve_level[n] != '0) n++;
    // Above the top point (also any nonzero level on an empty list).
    if (lv > curve_level[0]) begin
      r.above_top = 1'b1;
      return r;
    end
    // First point at or below the level; k == n is the implicit end point.
    k = 0;
    while (k < n && lv < curve_level[k]) k++;
    lo_l = 0;
    lo_v = 0;
    if (k < n) lo_l = curve_level[k];
    // The end point carries the next register's value unless all four are used.
    if (k < NUM_POINTS) lo_v = curve_value[k];
    if (k == 0 || lv >= FLAT_LEVEL || lo_v == 0) begin
      r.drive_value = value_t'(lo_v);
    end else begin
      hi_l = curve_level[k-1];
      hi_v = curve_value[k-1];
      // A falling value toward the upper point, or an upper level not above the lower one, flattens the segment.
      if (hi_v < lo_v || hi_l <= lo_l) begin
        r.drive_value = value_t'(lo_v);
      end else begin
        num = 64'(lv - lo_l) * 64'(hi_v - lo_v);
        r.drive_value = value_t'(num / 64'(hi_l - lo_l) + 64'(lo_v));
      end
    end
    return r;
  endfunction

  // Offer one level, with an optional leading gap; return at the accepting edge.
  task automatic send_level(input level_t lv);
    int g;
    @(negedge clk);
    g = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.level <= lv;
    do @(posedge clk); while (!in_bus.ready);
    drive_expect.push_back(map_level(lv));
  endtask

  // Drop valid, then hold until every owed beat is back and the pipe is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (drive_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight breakpoint registers back to back while the block is idle.
  // Level writes carry random junk above the level width; the block drops it.
  task automatic apply_curve(input lvl_set_t lv, input val_set_t vv);
    cfg_idx_t  regs [2*NUM_POINTS];
    cfg_data_t d;
    regs = '{REG_LEVEL_P0, REG_LEVEL_P1, REG_LEVEL_P2, REG_LEVEL_P3,
             REG_VALUE_P0, REG_VALUE_P1, REG_VALUE_P2, REG_VALUE_P3};
    wait_idle();
    foreach (regs[i]) begin
      if (regs[i] <= REG_LEVEL_P3) begin
        d = cfg_data_t'($urandom);
        d[LEVEL_BITS-1:0] = lv[regs[i] - REG_LEVEL_P0];
      end else begin
        d = cfg_data_t'(vv[regs[i] - REG_VALUE_P0]);
      end
      @(negedge clk);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= regs[i];
      cfg_bus.data  <= d;
      do @(posedge clk); while (!cfg_bus.ready);
      if (regs[i] <= REG_LEVEL_P3) curve_level[regs[i] - REG_LEVEL_P0] = level_t'(d);
      else curve_value[regs[i] - REG_VALUE_P0] = value_t'(d);
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Random curve: mostly sorted levels with falling values, sometimes unsorted
  // levels, rising values or a zero-value point. Registers past the end are junk.
  task automatic make_random_curve(output lvl_set_t lv, output val_set_t vv);
    int unsigned lsort [$];
    int unsigned vsort [$];
    int n;
    int span;
    n    = $urandom_range(1, NUM_POINTS);
    span = $urandom_range(0, 1) ? 300 : LEVEL_MAX;
    for (int i = 0; i < NUM_POINTS; i++) begin
      lsort.push_back($urandom_range(1, span));
      vsort.push_back($urandom_range(0, VALUE_MAX));
    end
    if ($urandom_range(0, 4) != 0) lsort.rsort();
    if ($urandom_range(0, 4) != 0) vsort.rsort();
    if ($urandom_range(0, 3) == 0) vsort[$urandom_range(0, NUM_POINTS-1)] = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (i < n) lv[i] = level_t'(lsort[i]);
      else if (i == n) lv[i] = '0;
      else lv[i] = level_t'($urandom_range(0, LEVEL_MAX));
      vv[i] = value_t'(vsort[i]);
    end
  endtask

  // Mostly levels in the interpolating range, some at or next to a breakpoint,
  // the rest anywhere.
  function automatic level_t pick_level();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 5) v = $urandom_range(0, 300);
    else if (r < 7) v = int'(curve_level[$urandom_range(0, NUM_POINTS-1)])
                        + int'($urandom_range(0, 2)) - 1;
    else v = $urandom_range(0, LEVEL_MAX);
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return level_t'(v);
  endfunction

  // Compare each drive beat with the oldest owed one.
  always @(posedge clk) begin : check_drive
    drive_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (drive_expect.size() == 0) begin
        $error("unexpected drive beat: drive_value %0d above_top %0b",
               out_bus.drive_value, out_bus.above_top);
        err_count++;
      end else begin
        want = drive_expect.pop_front();
        if (out_bus.drive_value !== want.drive_value) begin
          $error("drive_value mismatch: expected %0d, got %0d",
                 want.drive_value, out_bus.drive_value);
          err_count++;
        end
        if (out_bus.above_top !== want.above_top) begin
          $error("above_top mismatch: expected %0b, got %0b",
                 want.above_top, out_bus.above_top);
          err_count++;
        end
      end
    end
  end

  // Registers straight out of reset: empty list, so level 0 maps to value_p0
  // and anything above 0 is above the top.
  task automatic test_reset_curve();
    send_level(level_t'(0));
    send_level(level_t'(1));
    send_level(level_t'(LEVEL_MAX));
  endtask

  // Hand-picked curves that hit each corner of the search and the flat rules.
  task automatic test_curve_corners();
    lvl_set_t lv;
    val_set_t vv;
    // Three points; the end point takes value_p3.
    lv = '{200, 100, 50, 0};
    vv = '{1000, 600, 200, 77};
    apply_curve(lv, vv);
    send_level(level_t'(200));  // exactly at top
    send_level(level_t'(201));  // just above top
    send_level(level_t'(150));
    send_level(level_t'(100));  // exactly on a point
    send_level(level_t'(10));   // toward the end point
    send_level(level_t'(0));
    // Four points, extremes; the end point is zero, flat at and above 255.
    lv = '{LEVEL_MAX, 600, 254, 3};
    vv = '{VALUE_MAX, 40000, 100, 5};
    apply_curve(lv, vv);
    send_level(level_t'(LEVEL_MAX));
    send_level(level_t'(300));
    send_level(level_t'(254));
    send_level(level_t'(2));
    send_level(level_t'(255));
    // Falling value toward the upper point, and a zero-value point.
    lv = '{240, 120, 60, 0};
    vv = '{500, 900, 0, 30};
    apply_curve(lv, vv);
    send_level(level_t'(200));
    send_level(level_t'(100));
    send_level(level_t'(30));
    // Unsorted levels; the search runs as written.
    lv = '{100, 300, 50, 0};
    vv = '{2000, 1000, 500, 0};
    apply_curve(lv, vv);
    send_level(level_t'(90));
    send_level(level_t'(99));
    send_level(level_t'(250));
  endtask

  // Stall the result side long enough to fill the block and stall its input,
  // then pause the sender until everything is back, then push again.
  task automatic test_backpressure();
    lvl_set_t lv;
    val_set_t vv;
    make_random_curve(lv, vv);
    apply_curve(lv, vv);
    -> long_hold;
    repeat (40) send_level(pick_level());
    wait_idle();
    repeat (20) send_level(pick_level());
  endtask

  // Bulk of the run: a dozen curves, extremes first, ~100 levels each.
  task automatic test_random_curves();
    lvl_set_t lv;
    val_set_t vv;
    for (int c = 0; c < 12; c++) begin
      if (c == 0) begin
        lv = '{default: level_t'(LEVEL_MAX)};
        vv = '{default: value_t'(VALUE_MAX)};
      end else if (c == 1) begin
        lv = '{default: '0};
        foreach (vv[i]) vv[i] = value_t'($urandom_range(0, VALUE_MAX));
      end else begin
        make_random_curve(lv, vv);
      end
      apply_curve(lv, vv);
      if (c == 6) -> long_hold;
      repeat (100) send_level(pick_level());
    end
  endtask

  // Tail: no idling on either side, levels back to back.
  task automatic test_back_to_back();
    lvl_set_t lv;
    val_set_t vv;
    make_random_curve(lv, vv);
    apply_curve(lv, vv);
    idle_on = 1'b0;
    repeat (170) send_level(pick_level());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.level  = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_curve();
    test_curve_corners();
    test_backpressure();
    test_random_curves();
    test_back_to_back();

    // Drain: every owed beat back, then let the pipe sit a while.
    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
